// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the checker module bts_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that cond is followed by result on the next edge
`define ASSERT_NEXT(label, clk, rst_n, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error(msg);

`endif

// ===== rtl/core/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg
// Types and constants of the bilinear texel sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 8;
    localparam int INT_W     = COORD_W - FRAC_BITS;
    localparam int SIDE_W    = 9;
    localparam int TEXEL_W   = 32;
    localparam int CH_W      = 8;
    localparam int V_W       = CH_W + FRAC_BITS;
    localparam int H_W       = V_W + FRAC_BITS;
    localparam int NUM_CH    = 3;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    localparam logic [CH_W-1:0]   ALPHA_OPAQUE = 8'hff;
    localparam logic [SIDE_W-1:0] SIDE_RESET   = 9'd256;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic REG_TILE_WIDTH  = 1'b0;
    localparam logic REG_TILE_HEIGHT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [TEXEL_W-1:0] texel_in;
    } bts_req_t;

    typedef struct packed {
        logic [TEXEL_W-1:0] color_out;
        logic               out_of_range;
    } bts_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_TL,
        ST_RD_BL,
        ST_RD_TR,
        ST_RD_BR,
        ST_VL,
        ST_VR,
        ST_H,
        ST_DONE
    } bts_state_t;

endpackage

// ===== rtl/core/bilinear_texel_sampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_texel_sampler
// Texel tile in one synchronous memory with a per-channel bilinear blender.
// ----------------------------------------------------------------------------
// A write inside the tile stores its texel at the edge that accepts it; one
// outside is dropped. For a sample inside, the single read port of the texel
// memory fetches the four neighbors, one shared multiplier per colour channel
// runs the left, right and horizontal blends in turn, and the result register
// loads when the output is free; a sample outside the tile skips the reads and
// blends. req_stall stays high while a sample is in work, so a read never
// overlaps a write. A finished result waits in the output register while the
// next item is taken. The memory needs no clearing pass after reset if the
// user writes a texel before a sample reads it; the block does not enforce it.
// ----------------------------------------------------------------------------
module bilinear_texel_sampler
    import bts_pkg::*;
#(
    parameter int MAX_SIDE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               req_valid,
    output logic               req_stall,
    input  bts_req_t           req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output bts_rsp_t           rsp
);

    localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int DEPTH = 2 ** (2 * AW);
    localparam logic [SIDE_W-1:0] SIDE_CAP =
        (MAX_SIDE > 511) ? 9'd511 : SIDE_W'(MAX_SIDE);

    logic [TEXEL_W-1:0] mem [0:DEPTH-1];

    bts_state_t          state_reg, state_next;
    logic [SIDE_W-1:0]   tile_width_reg, tile_height_reg;
    logic [SIDE_W-1:0]   w_eff, h_eff;
    logic [INT_W-1:0]    ix_reg, iy_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;
    logic                oor_reg, bot_reg, right_reg;
    logic [TEXEL_W-1:0]  tl_reg, bl_reg, tr_reg, br_reg;
    logic [TEXEL_W-1:0]  rd_data_reg;
    logic [V_W-1:0]      vl_reg [NUM_CH];
    logic [V_W-1:0]      vr_reg [NUM_CH];
    logic [CH_W-1:0]     h_reg  [NUM_CH];
    logic [H_W-1:0]      blend_res [NUM_CH];
    bts_rsp_t            rsp_reg, rsp_next;
    logic                rsp_valid_reg;

    logic [SIDE_W-1:0]   req_ix, req_iy;
    logic                req_inside;
    logic                accept, load;
    logic                cfg_wr;
    logic                wr_en, rd_en;
    logic [2*AW-1:0]     wr_addr, rd_addr;
    logic [AW-1:0]       x0, x1, y0, y1;

    function automatic logic [H_W-1:0] blend(logic [V_W-1:0] a, logic [V_W-1:0] b,
                                             logic [FRAC_BITS-1:0] f);
        logic signed [V_W:0]       d;
        logic signed [FRAC_BITS:0] fs;
        logic signed [H_W+1:0]     p;
        logic signed [H_W+1:0]     s;
        d  = signed'({1'b0, b}) - signed'({1'b0, a});
        fs = signed'({1'b0, f});
        p  = d * fs;
        s  = signed'({2'b00, a, {FRAC_BITS{1'b0}}}) + p;
        return s[H_W-1:0];
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_TILE_WIDTH:  prdata = DATA_W'(tile_width_reg);
            REG_TILE_HEIGHT: prdata = DATA_W'(tile_height_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg  <= SIDE_RESET;
            tile_height_reg <= SIDE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_TILE_WIDTH:  tile_width_reg  <= pwdata[SIDE_W-1:0];
                REG_TILE_HEIGHT: tile_height_reg <= pwdata[SIDE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        w_eff = tile_width_reg;
        if (tile_width_reg == '0)
            w_eff = SIDE_W'(1);
        else if (tile_width_reg > SIDE_CAP)
            w_eff = SIDE_CAP;
        h_eff = tile_height_reg;
        if (tile_height_reg == '0)
            h_eff = SIDE_W'(1);
        else if (tile_height_reg > SIDE_CAP)
            h_eff = SIDE_CAP;
    end

    assign req_ix     = {1'b0, req.coord_x[COORD_W-1:FRAC_BITS]};
    assign req_iy     = {1'b0, req.coord_y[COORD_W-1:FRAC_BITS]};
    assign req_inside = (req_ix < w_eff) && (req_iy < h_eff);
    assign accept     = req_valid && !req_stall;
    assign load       = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    assign wr_en   = accept && (req.cmd == CMD_WRITE) && req_inside;
    assign wr_addr = {AW'(req_iy), AW'(req_ix)};

    assign x0 = AW'(ix_reg);
    assign x1 = AW'({1'b0, ix_reg} + SIDE_W'(1));
    assign y0 = AW'(iy_reg);
    assign y1 = AW'({1'b0, iy_reg} + SIDE_W'(1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= req.texel_in;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = {y0, x0};
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid && req.cmd == CMD_SAMPLE)
                    state_next = req_inside ? ST_RD_TL : ST_DONE;
            end
            ST_RD_TL:
            begin
                rd_en      = 1'b1;
                rd_addr    = {y0, x0};
                state_next = ST_RD_BL;
            end
            ST_RD_BL:
            begin
                rd_en      = 1'b1;
                rd_addr    = {y1, x0};
                state_next = ST_RD_TR;
            end
            ST_RD_TR:
            begin
                rd_en      = 1'b1;
                rd_addr    = {y0, x1};
                state_next = ST_RD_BR;
            end
            ST_RD_BR:
            begin
                rd_en      = 1'b1;
                rd_addr    = {y1, x1};
                state_next = ST_VL;
            end
            ST_VL:   state_next = ST_VR;
            ST_VR:   state_next = ST_H;
            ST_H:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && req.cmd == CMD_SAMPLE)
        begin
            ix_reg    <= req.coord_x[COORD_W-1:FRAC_BITS];
            iy_reg    <= req.coord_y[COORD_W-1:FRAC_BITS];
            fx_reg    <= req.coord_x[FRAC_BITS-1:0];
            fy_reg    <= req.coord_y[FRAC_BITS-1:0];
            oor_reg   <= !req_inside;
            bot_reg   <= (req_iy + SIDE_W'(1)) < h_eff;
            right_reg <= (req_ix + SIDE_W'(1)) < w_eff;
        end
        if (state_reg == ST_RD_BL)
            tl_reg <= rd_data_reg;
        if (state_reg == ST_RD_TR)
            bl_reg <= rd_data_reg;
        if (state_reg == ST_RD_BR)
            tr_reg <= rd_data_reg;
        if (state_reg == ST_VL)
            br_reg <= rd_data_reg;
    end

    always_comb
    begin
        logic [V_W-1:0]       op_a;
        logic [V_W-1:0]       op_b;
        logic [FRAC_BITS-1:0] op_f;
        for (int c = 0; c < NUM_CH; c++)
        begin
            case (state_reg)
                ST_VL:
                begin
                    op_a = V_W'(tl_reg[CH_W*(NUM_CH-1-c) +: CH_W]);
                    op_b = V_W'(bl_reg[CH_W*(NUM_CH-1-c) +: CH_W]);
                    op_f = fy_reg;
                end
                ST_VR:
                begin
                    if (bot_reg)
                    begin
                        op_a = V_W'(tr_reg[CH_W*(NUM_CH-1-c) +: CH_W]);
                        op_b = V_W'(br_reg[CH_W*(NUM_CH-1-c) +: CH_W]);
                        op_f = fy_reg;
                    end
                    else
                    begin
                        op_a = V_W'(tl_reg[CH_W*(NUM_CH-1-c) +: CH_W]);
                        op_b = V_W'(tr_reg[CH_W*(NUM_CH-1-c) +: CH_W]);
                        op_f = fx_reg;
                    end
                end
                default:
                begin
                    op_a = vl_reg[c];
                    op_b = vr_reg[c];
                    op_f = fx_reg;
                end
            endcase
            blend_res[c] = blend(op_a, op_b, op_f);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (state_reg == ST_VL)
                vl_reg[c] <= blend_res[c][V_W-1:0];
            if (state_reg == ST_VR)
                vr_reg[c] <= blend_res[c][V_W-1:0];
            if (state_reg == ST_H)
                h_reg[c] <= blend_res[c][H_W-1:V_W];
        end
    end

    always_comb
    begin
        rsp_next.out_of_range = oor_reg;
        if (oor_reg)
            rsp_next.color_out = '0;
        else if (bot_reg && right_reg)
            rsp_next.color_out = {ALPHA_OPAQUE, h_reg[0], h_reg[1], h_reg[2]};
        else if (bot_reg)
            rsp_next.color_out = {ALPHA_OPAQUE, vl_reg[0][V_W-1:FRAC_BITS],
                                  vl_reg[1][V_W-1:FRAC_BITS], vl_reg[2][V_W-1:FRAC_BITS]};
        else if (right_reg && fx_reg != '0)
            rsp_next.color_out = {ALPHA_OPAQUE, vr_reg[0][V_W-1:FRAC_BITS],
                                  vr_reg[1][V_W-1:FRAC_BITS], vr_reg[2][V_W-1:FRAC_BITS]};
        else
            rsp_next.color_out = tl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (load)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/bts_checker.sv =====
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks of the bilinear texel sampler, bound into each sampler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bts_checker
    import bts_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input bts_req_t req,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input bts_rsp_t rsp
);

    logic rsp_wait;
    logic rsp_oor;
    logic take_sample;
    logic take_write;

    assign rsp_wait    = rsp_valid && rsp_stall;
    assign rsp_oor     = rsp_valid && rsp.out_of_range;
    assign take_sample = req_valid && !req_stall && req.cmd == CMD_SAMPLE;
    assign take_write  = req_valid && !req_stall && req.cmd == CMD_WRITE;

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_wait, rsp_valid, "result item dropped")
    `ASSERT_CLK(a_oor_zero, clk, rst_n, rsp_oor |-> rsp.color_out == '0, "color not zero")
    `ASSERT_NEXT(a_sample_busy, clk, rst_n, take_sample, req_stall, "sample not held off")
    `ASSERT_NEXT(a_write_silent, clk, rst_n, take_write, !$rose(rsp_valid), "write gave a result")

endmodule

bind bilinear_texel_sampler bts_checker u_bts_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilinear texel sampler. A scoreboard keeps its
// own copy of the texel tile and the tile size and works out the color that
// each accepted sample must return. Stimulus opens with a directed pass over
// every edge case on a 3x2 tile, then runs random phases across tile sizes
// from 1x1 to 256x256, zero and oversized register values included, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
    import bts_pkg::*;

    localparam int STORE_SIDE     = 256;
    localparam int AXIS_SPAN      = 1 << INT_W;
    localparam int ONE_FX         = 1 << FRAC_BITS;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 75;
    localparam int NUM_PHASES     = 8;

    typedef enum int {
        KIND_BLEND,
        KIND_LAST_COL,
        KIND_ROW_BLEND,
        KIND_ROW_COPY,
        KIND_CORNER,
        KIND_OUTSIDE
    } sample_kind_t;

    class sample_scoreboard;
        logic [TEXEL_W-1:0] texels [0:STORE_SIDE*STORE_SIDE-1];
        bit                 written [0:STORE_SIDE*STORE_SIDE-1];
        int unsigned        width_eff;
        int unsigned        height_eff;
        bts_rsp_t           expected_q [$];
        sample_kind_t       last_kind;
        int                 kind_count [0:5];
        int                 mismatches;
        int                 texel_writes;
        int                 ignored_writes;
        int                 results_checked;

        function new();
            width_eff  = 32'(SIDE_RESET);
            height_eff = 32'(SIDE_RESET);
        endfunction

        function int unsigned clamp_side(logic [SIDE_W-1:0] value);
            if (value == 0)
                return 1;
            if (value > STORE_SIDE)
                return STORE_SIDE;
            return 32'(value);
        endfunction

        function void set_register(logic idx, logic [SIDE_W-1:0] value);
            if (idx == REG_TILE_WIDTH)
                width_eff = clamp_side(value);
            else
                height_eff = clamp_side(value);
        endfunction

        function logic [TEXEL_W-1:0] texel_at(int unsigned x, int unsigned y);
            return texels[y * STORE_SIDE + x];
        endfunction

        function int unsigned channel(logic [TEXEL_W-1:0] texel, int s);
            return (texel >> (CH_W * (NUM_CH - 1 - s))) & 8'hff;
        endfunction

        function int unsigned mix(int unsigned a, int unsigned b, int unsigned f);
            return (ONE_FX - f) * a + f * b;
        endfunction

        function bts_rsp_t predict(bts_req_t r);
            int unsigned        ix, iy, fx, fy, vl, vr;
            bit                 has_bottom, has_right;
            logic [TEXEL_W-1:0] tl, tr, bl, br;
            logic [CH_W-1:0]    ch [NUM_CH];
            bts_rsp_t           res;
            ix = 32'(r.coord_x >> FRAC_BITS);
            iy = 32'(r.coord_y >> FRAC_BITS);
            fx = 32'(r.coord_x[FRAC_BITS-1:0]);
            fy = 32'(r.coord_y[FRAC_BITS-1:0]);
            res.color_out    = '0;
            res.out_of_range = 1'b0;
            if (ix >= width_eff || iy >= height_eff)
            begin
                res.out_of_range = 1'b1;
                last_kind = KIND_OUTSIDE;
                return res;
            end
            tl = texel_at(ix, iy);
            has_bottom = iy + 1 < height_eff;
            has_right  = ix + 1 < width_eff;
            if (has_bottom)
            begin
                bl = texel_at(ix, iy + 1);
                if (has_right)
                begin
                    tr = texel_at(ix + 1, iy);
                    br = texel_at(ix + 1, iy + 1);
                    for (int s = 0; s < NUM_CH; s++)
                    begin
                        vl = mix(channel(tl, s), channel(bl, s), fy);
                        vr = mix(channel(tr, s), channel(br, s), fy);
                        ch[s] = CH_W'(mix(vl, vr, fx) >> (2 * FRAC_BITS));
                    end
                    last_kind = KIND_BLEND;
                end
                else
                begin
                    for (int s = 0; s < NUM_CH; s++)
                        ch[s] = CH_W'(mix(channel(tl, s), channel(bl, s), fy) >> FRAC_BITS);
                    last_kind = KIND_LAST_COL;
                end
                res.color_out = {ALPHA_OPAQUE, ch[0], ch[1], ch[2]};
            end
            else if (has_right && fx != 0)
            begin
                tr = texel_at(ix + 1, iy);
                for (int s = 0; s < NUM_CH; s++)
                    ch[s] = CH_W'(mix(channel(tl, s), channel(tr, s), fx) >> FRAC_BITS);
                res.color_out = {ALPHA_OPAQUE, ch[0], ch[1], ch[2]};
                last_kind = KIND_ROW_BLEND;
            end
            else
            begin
                res.color_out = tl;
                last_kind = has_right ? KIND_ROW_COPY : KIND_CORNER;
            end
            return res;
        endfunction

        function void note_request(bts_req_t r);
            int unsigned ix, iy;
            ix = 32'(r.coord_x >> FRAC_BITS);
            iy = 32'(r.coord_y >> FRAC_BITS);
            if (r.cmd == CMD_WRITE)
            begin
                if (ix < width_eff && iy < height_eff)
                begin
                    texels[iy * STORE_SIDE + ix]  = r.texel_in;
                    written[iy * STORE_SIDE + ix] = 1'b1;
                    texel_writes++;
                end
                else
                    ignored_writes++;
            end
            else
            begin
                expected_q.push_back(predict(r));
                kind_count[last_kind]++;
            end
        endfunction

        function void report(string what, bts_rsp_t want, bts_rsp_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected color %h range %b, got color %h range %b",
                         $time, what, want.color_out, want.out_of_range,
                         got.color_out, got.out_of_range);
        endfunction

        function void check_result(bts_rsp_t got);
            bts_rsp_t want;
            results_checked++;
            if (expected_q.size() == 0)
            begin
                report("result with no sample pending", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.color_out !== want.color_out || got.out_of_range !== want.out_of_range)
                report("color mismatch", want, got);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b1;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               req_valid = 1'b0;
    logic               req_stall;
    bts_req_t           req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    bts_rsp_t           rsp;

    sample_scoreboard   board;
    bit                 quiet       = 1'b0;
    int                 items_sent  = 0;
    int                 idle_cycles = 0;
    int unsigned        stall_hold  = 0;

    bilinear_texel_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [COORD_W-1:0] pick_axis(int unsigned side);
        int unsigned r, ipart, fpart;
        r = $urandom_range(0, 99);
        if (r < 20)
            ipart = side - 1;
        else if (r < 30 && side > 1)
            ipart = side - 2;
        else if (r < 40 && side < AXIS_SPAN)
            ipart = $urandom_range(side, AXIS_SPAN - 1);
        else
            ipart = $urandom_range(0, side - 1);
        r = $urandom_range(0, 9);
        if (r < 2)
            fpart = 0;
        else if (r == 2)
            fpart = ONE_FX - 1;
        else
            fpart = $urandom_range(0, ONE_FX - 1);
        return {ipart[INT_W-1:0], fpart[FRAC_BITS-1:0]};
    endfunction

    // sample and item monitors
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_result(rsp);
        if (rst_n && req_valid && !req_stall)
            board.note_request(req);
    end

    always @(negedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            rsp_stall  <= !quiet && ($urandom_range(0, 2) == 0);
            stall_hold <= quiet ? 0 : pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(input bts_req_t item);
        int unsigned gap;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       = item;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic write_texel(input int unsigned x, input int unsigned y,
                               input logic [TEXEL_W-1:0] texel);
        bts_req_t item;
        item.cmd      = CMD_WRITE;
        item.coord_x  = {x[INT_W-1:0], FRAC_BITS'($urandom)};
        item.coord_y  = {y[INT_W-1:0], FRAC_BITS'($urandom)};
        item.texel_in = texel;
        send_item(item);
        items_sent++;
    endtask

    task automatic ensure_texel(input int unsigned x, input int unsigned y);
        if (!board.written[y * STORE_SIDE + x])
            write_texel(x, y, $urandom);
    endtask

    // load any unwritten neighbor the sample's result uses, then send the sample
    task automatic sample_at(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
        int unsigned ix, iy;
        bit          has_bottom, has_right;
        bts_req_t    item;
        ix = 32'(cx >> FRAC_BITS);
        iy = 32'(cy >> FRAC_BITS);
        if (ix < board.width_eff && iy < board.height_eff)
        begin
            has_bottom = iy + 1 < board.height_eff;
            has_right  = ix + 1 < board.width_eff;
            ensure_texel(ix, iy);
            if (has_bottom)
                ensure_texel(ix, iy + 1);
            if (has_right && (has_bottom || cx[FRAC_BITS-1:0] != 0))
                ensure_texel(ix + 1, iy);
            if (has_right && has_bottom)
                ensure_texel(ix + 1, iy + 1);
        end
        item.cmd      = CMD_SAMPLE;
        item.coord_x  = cx;
        item.coord_y  = cy;
        item.texel_in = $urandom;
        send_item(item);
        items_sent++;
    endtask

    task automatic drain_results();
        req_valid = 1'b0;
        do
            @(negedge clk);
        while (board.pending() != 0);
    endtask

    task automatic write_register(input logic idx, input logic [SIDE_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_tile(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_register(REG_TILE_WIDTH, w);
        write_register(REG_TILE_HEIGHT, h);
    endtask

    initial
    begin
        bts_req_t          noise;
        int                phase_end;
        int unsigned       r;
        logic [SIDE_W-1:0] phase_w [NUM_PHASES];
        logic [SIDE_W-1:0] phase_h [NUM_PHASES];
        int                failures;

        board = new();
        phase_w = '{9'd256, 9'd0, 9'd1, 9'd256, 9'd2, 9'd300, 9'd7, 9'd511};
        phase_h = '{9'd256, 9'd0, 9'd256, 9'd1, 9'd2, 9'd257, 9'd5, 9'd3};
        phase_w[6] = SIDE_W'($urandom_range(3, 16));
        phase_h[6] = SIDE_W'($urandom_range(3, 16));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed pass on a 3x2 tile
        set_tile(9'd3, 9'd2);
        write_texel(0, 0, 32'hffffffff);
        write_texel(1, 0, 32'h00000000);
        write_texel(2, 0, $urandom);
        write_texel(0, 1, $urandom);
        write_texel(1, 1, $urandom);
        write_texel(2, 1, $urandom);
        sample_at(16'h0000, 16'h0000);
        sample_at(16'h01ff, 16'h00ff);
        sample_at(16'h0080, 16'h0040);
        sample_at(16'h0280, 16'h0080);
        sample_at(16'h0000, 16'h01ff);
        sample_at(16'h0140, 16'h0100);
        sample_at(16'h01ff, 16'h0100);
        sample_at(16'h02ff, 16'h01ff);
        sample_at(16'h0300, 16'h0000);
        sample_at(16'h0000, 16'h0200);
        sample_at(16'hffff, 16'hffff);
        noise = '{cmd: CMD_WRITE, coord_x: 16'hffff, coord_y: 16'hffff,
                  texel_in: 32'hffffffff};
        send_item(noise);
        sample_at(16'h0200, 16'h0100);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_tile(phase_w[p], phase_h[p]);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 39) == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 70)
                    sample_at(pick_axis(board.width_eff), pick_axis(board.height_eff));
                else if (r < 88)
                    write_texel($urandom_range(0, board.width_eff - 1),
                                $urandom_range(0, board.height_eff - 1), $urandom);
                else
                begin
                    noise.cmd      = CMD_WRITE;
                    noise.coord_x  = COORD_W'($urandom);
                    noise.coord_y  = COORD_W'($urandom);
                    noise.texel_in = $urandom;
                    send_item(noise);
                end
                // hold the sender until every sample has returned
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d texel writes (%0d off-tile) and %0d results over %0d tile sizes.",
                 board.texel_writes, board.ignored_writes, board.results_checked,
                 NUM_PHASES + 1);
        $display({"Samples: interior %0d, last column %0d, last row blend %0d,",
                  " copy %0d, corner %0d, outside %0d."},
                 board.kind_count[KIND_BLEND], board.kind_count[KIND_LAST_COL],
                 board.kind_count[KIND_ROW_BLEND], board.kind_count[KIND_ROW_COPY],
                 board.kind_count[KIND_CORNER], board.kind_count[KIND_OUTSIDE]);
        failures = board.mismatches + board.pending();
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== bilinear_texel_sampler.f =====
+incdir+rtl/core
rtl/core/bts_pkg.sv
rtl/core/bilinear_texel_sampler.sv
rtl/core/bts_checker.sv
sim/testbench.sv
